>>> hw/rtl/qxm_pkg.sv
// shared types, constants and helpers for the quad x motor mixer
`timescale 1ns / 1ps

package qxm_pkg;

  typedef logic [9:0] pwm_t;
  typedef pwm_t [3:0] motor_set_t;

  typedef struct packed {
    logic signed [15:0] thrust;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } cmd_t;

  localparam int unsigned MOTOR_FR = 0;
  localparam int unsigned MOTOR_FL = 1;
  localparam int unsigned MOTOR_RL = 2;
  localparam int unsigned MOTOR_RR = 3;

  localparam pwm_t              PWM_MAX      = 10'd999;
  localparam logic signed [17:0] PWM_MAX_S   = 18'sd999;
  localparam logic signed [11:0] STICK_OFFSET = 12'sd500;
  localparam logic [7:0]        IDLE_LIMIT   = 8'd30;

  localparam logic [15:0] STEP_FL   = 16'd200;
  localparam logic [15:0] STEP_RL   = 16'd400;
  localparam logic [15:0] STEP_RR   = 16'd600;
  localparam logic [15:0] STEP_DONE = 16'd800;
  localparam logic [15:0] PREP_TIME = 16'd1800;

  // saturate a wide signed sum into the pwm range
  function automatic pwm_t clamp_pwm(input logic signed [17:0] v);
    pwm_t r;
    if (v < 18'sd0) begin
      r = '0;
    end else if (v > PWM_MAX_S) begin
      r = PWM_MAX;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/qxm_mixer.sv
// x-frame mixer: four signed sums, each clamped to the pwm range
`timescale 1ns / 1ps

module qxm_mixer (
  input  qxm_pkg::cmd_t      cmd_i,
  output qxm_pkg::motor_set_t pwm_o
);

  logic signed [17:0] thr, yaw, rol, pit;
  logic signed [17:0] base_p, base_m, att_p, att_m;

  assign thr = 18'(cmd_i.thrust);
  assign yaw = 18'(cmd_i.yaw);
  assign rol = 18'(cmd_i.roll);
  assign pit = 18'(cmd_i.pitch);

  // share the thrust/yaw pairs between motors
  assign base_p = thr + yaw;
  assign base_m = thr - yaw;
  assign att_p  = pit - rol;
  assign att_m  = rol - pit;

  always_comb begin
    pwm_o[qxm_pkg::MOTOR_FR] = qxm_pkg::clamp_pwm(base_p + att_p);
    pwm_o[qxm_pkg::MOTOR_FL] = qxm_pkg::clamp_pwm(base_m + rol + pit);
    pwm_o[qxm_pkg::MOTOR_RL] = qxm_pkg::clamp_pwm(base_p + att_m);
    pwm_o[qxm_pkg::MOTOR_RR] = qxm_pkg::clamp_pwm(base_m - rol - pit);
  end

endmodule

>>> hw/rtl/quad_x_motor_mixer_sequencer.sv
// top level: arming spin-up sequencer and x mixer with input and result registers
`timescale 1ns / 1ps

// One control tick in, four pwm values out. A tick is captured in an input
// register, evaluated against the held motor values, spin-up timer and
// prepared flag, and placed in the result register, which raises
// out_valid_o; a new tick can be accepted every cycle as long as results are
// taken. The result register holds a finished result while the next tick
// waits in the input register. The idle setting is written through the cfg
// channel, which is always ready; write it only while no tick is in flight.

module quad_x_motor_mixer_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               esc_calibration_i,
  input  logic               armed_i,
  input  logic               taking_off_i,
  input  logic signed [9:0]  throttle_stick_i,
  input  logic [7:0]         dt_ms_i,
  input  logic signed [15:0] thrust_cmd_i,
  input  logic signed [15:0] yaw_cmd_i,
  input  logic signed [15:0] roll_cmd_i,
  input  logic signed [15:0] pitch_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         motor_front_right_o,
  output logic [9:0]         motor_front_left_o,
  output logic [9:0]         motor_rear_left_o,
  output logic [9:0]         motor_rear_right_o
);

  // configuration
  logic [7:0] idle_speed_q;

  // input register
  logic               s1_valid_q;
  logic               s1_calib_q, s1_armed_q, s1_takeoff_q;
  logic signed [9:0]  s1_stick_q;
  logic [7:0]         s1_dt_q;
  qxm_pkg::cmd_t      s1_cmd_q;

  // block state
  qxm_pkg::motor_set_t hold_q, hold_d;
  logic [15:0]         timer_q, timer_d;
  logic                prepared_q, prepared_d;

  // result register
  logic                out_valid_q;
  qxm_pkg::motor_set_t out_q, out_d;

  logic                advance;
  logic [4:0]          idle_lim;
  qxm_pkg::pwm_t       idle_pwm;
  logic [15:0]         timer_sum;
  qxm_pkg::pwm_t       calib_pwm;
  qxm_pkg::motor_set_t mix_pwm;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign idle_lim  = (idle_speed_q > qxm_pkg::IDLE_LIMIT) ? qxm_pkg::IDLE_LIMIT[4:0]
                                                           : idle_speed_q[4:0];
  // times ten as 8x + 2x
  assign idle_pwm  = {2'b00, idle_lim, 3'b000} + {4'b0000, idle_lim, 1'b0};
  assign timer_sum = timer_q + {8'h00, s1_dt_q};
  assign calib_pwm = qxm_pkg::clamp_pwm(18'(12'(s1_stick_q) + qxm_pkg::STICK_OFFSET));

  qxm_mixer u_mixer (
    .cmd_i (s1_cmd_q),
    .pwm_o (mix_pwm)
  );

  always_comb begin
    hold_d     = hold_q;
    timer_d    = timer_q;
    prepared_d = prepared_q;
    out_d      = hold_q;
    if (s1_calib_q) begin
      out_d = {4{calib_pwm}};
    end else if (!s1_armed_q) begin
      out_d      = '0;
      prepared_d = 1'b0;
    end else begin
      if (!prepared_q) begin
        timer_d = timer_sum;
        if (timer_sum < qxm_pkg::STEP_FL) begin
          hold_d                   = '0;
          hold_d[qxm_pkg::MOTOR_FR] = idle_pwm;
        end else if (timer_sum < qxm_pkg::STEP_RL) begin
          hold_d[qxm_pkg::MOTOR_FL] = idle_pwm;
        end else if (timer_sum < qxm_pkg::STEP_RR) begin
          hold_d[qxm_pkg::MOTOR_RL] = idle_pwm;
        end else if (timer_sum < qxm_pkg::STEP_DONE) begin
          hold_d[qxm_pkg::MOTOR_RR] = idle_pwm;
        end else if (timer_sum > qxm_pkg::PREP_TIME) begin
          prepared_d = 1'b1;
          timer_d    = '0;
        end
      end
      // mixing may start in the tick that finishes spin-up
      if (s1_takeoff_q && prepared_d) begin
        hold_d = mix_pwm;
      end
      out_d = hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_speed_q <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_q       <= '0;
      timer_q      <= '0;
      prepared_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        idle_speed_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        hold_q      <= hold_d;
        timer_q     <= timer_d;
        prepared_q  <= prepared_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_calib_q     <= esc_calibration_i;
      s1_armed_q     <= armed_i;
      s1_takeoff_q   <= taking_off_i;
      s1_stick_q     <= throttle_stick_i;
      s1_dt_q        <= dt_ms_i;
      s1_cmd_q.thrust <= thrust_cmd_i;
      s1_cmd_q.yaw    <= yaw_cmd_i;
      s1_cmd_q.roll   <= roll_cmd_i;
      s1_cmd_q.pitch  <= pitch_cmd_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign motor_front_right_o = out_q[qxm_pkg::MOTOR_FR];
  assign motor_front_left_o  = out_q[qxm_pkg::MOTOR_FL];
  assign motor_rear_left_o   = out_q[qxm_pkg::MOTOR_RL];
  assign motor_rear_right_o  = out_q[qxm_pkg::MOTOR_RR];

  a_prep_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(prepared_q) |-> timer_q == 16'd0)
    else $error("prepared set without timer clear");

  a_disarm_clears_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !s1_calib_q && !s1_armed_q |=> !prepared_q)
    else $error("disarmed transaction left prepared set");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room available");

  a_pwm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> motor_front_right_o <= qxm_pkg::PWM_MAX
                 && motor_front_left_o <= qxm_pkg::PWM_MAX
                 && motor_rear_left_o <= qxm_pkg::PWM_MAX
                 && motor_rear_right_o <= qxm_pkg::PWM_MAX)
    else $error("pwm value out of range");

  a_timer_held_when_prepared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(prepared_q) && prepared_q |-> $stable(timer_q))
    else $error("spin-up timer moved while prepared");

endmodule

>>> tb/quad_x_motor_mixer_sequencer_test.sv
// self-checking testbench for the quad x motor mixer and spin-up sequencer
`timescale 1ns / 1ps

module quad_x_motor_mixer_sequencer_test;

  localparam int PWM_TOP       = 999;
  localparam int STICK_BIAS    = 500;
  localparam int IDLE_CAP      = 30;
  localparam int IDLE_GAIN     = 10;
  localparam int SPIN_FL_MS    = 200;
  localparam int SPIN_RL_MS    = 400;
  localparam int SPIN_RR_MS    = 600;
  localparam int SPIN_END_MS   = 800;
  localparam int SPIN_READY_MS = 1800;
  localparam int UNTYPED       = -1;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 5;
  localparam int PHASE_TICKS   = 400;

  typedef struct {
    bit                 calib;
    bit                 armed;
    bit                 takeoff;
    logic signed [9:0]  stick;
    logic [7:0]         dt;
    logic signed [15:0] thrust;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } tick_t;

  typedef struct packed {
    int calib, armed, takeoff, stick, dt, thrust, yaw, roll, pitch;
    int fr, fl, rl, rr;
  } row_t;

  // idle is written as 255 before this table, so the idle pwm is 300
  localparam row_t DIRECTED [0:23] = '{
    '{0, 0, 0,    0,   0,      0,      0,      0,      0,   0,   0,   0,   0},
    '{1, 0, 0, -512,   0,      0,      0,      0,      0,   0,   0,   0,   0},
    '{1, 0, 0, -500,   0,      0,      0,      0,      0,   0,   0,   0,   0},
    '{1, 0, 0,    0,   0,      0,      0,      0,      0, 500, 500, 500, 500},
    '{1, 0, 0,  499,   0,      0,      0,      0,      0, 999, 999, 999, 999},
    '{1, 0, 1,  511, 255,  32767, -32768,  32767, -32768, 999, 999, 999, 999},
    '{0, 1, 0,    0,   0,      0,      0,      0,      0, 300,   0,   0,   0},
    '{0, 1, 0,    0, 200,      0,      0,      0,      0, 300, 300,   0,   0},
    '{0, 1, 0,    0, 200,      0,      0,      0,      0, 300, 300, 300,   0},
    '{0, 0, 1,    0, 200,      0,      0,      0,      0,   0,   0,   0,   0},
    '{0, 1, 0,    0, 200,      0,      0,      0,      0, 300, 300, 300, 300},
    '{0, 1, 1,    0, 255,    800,      0,      0,      0, 300, 300, 300, 300},
    '{0, 1, 0,    0, 255,      0,      0,      0,      0, 300, 300, 300, 300},
    '{0, 1, 0,    0, 255,      0,      0,      0,      0, 300, 300, 300, 300},
    '{0, 1, 0,    0, 255,      0,      0,      0,      0, 300, 300, 300, 300},
    '{0, 1, 0,    0, 180,      0,      0,      0,      0, 300, 300, 300, 300},
    '{0, 1, 1,    0,   1,  32767,  32767, -32768,  32767, 999,   0,   0,   1},
    '{0, 1, 1,    0,   0, -32768, -32768,  32767, -32768,   0,   0,   0,   1},
    '{0, 1, 1,    0,   0,    500,     10,    -20,     30,
      UNTYPED, UNTYPED, UNTYPED, UNTYPED},
    '{0, 1, 0,    0, 255,      0,      0,      0,      0,
      UNTYPED, UNTYPED, UNTYPED, UNTYPED},
    '{1, 1, 1,  100,   0,      0,      0,      0,      0, 600, 600, 600, 600},
    '{0, 1, 0,   -1, 255,     -1,     -1,     -1,     -1,
      UNTYPED, UNTYPED, UNTYPED, UNTYPED},
    '{0, 0, 0,    0,   0,      0,      0,      0,      0,   0,   0,   0,   0},
    '{0, 1, 1,    0,   0,    900,      0,      0,      0, 300,   0,   0,   0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               esc_calibration_i;
  logic               armed_i;
  logic               taking_off_i;
  logic signed [9:0]  throttle_stick_i;
  logic [7:0]         dt_ms_i;
  logic signed [15:0] thrust_cmd_i;
  logic signed [15:0] yaw_cmd_i;
  logic signed [15:0] roll_cmd_i;
  logic signed [15:0] pitch_cmd_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [9:0]         motor_front_right_o;
  logic [9:0]         motor_front_left_o;
  logic [9:0]         motor_rear_left_o;
  logic [9:0]         motor_rear_right_o;

  // predictor state
  logic [7:0]          idle_cfg;
  qxm_pkg::motor_set_t held;
  logic [15:0]         spin_ms;
  bit                  spun_up;

  qxm_pkg::motor_set_t pending_pwm [$];
  int                  mix_errors;
  bit                  calm;
  string       motor_name [4] = '{"front_right", "front_left", "rear_left", "rear_right"};

  always #5 clk_i = ~clk_i;

  quad_x_motor_mixer_sequencer i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .esc_calibration_i  (esc_calibration_i),
    .armed_i            (armed_i),
    .taking_off_i       (taking_off_i),
    .throttle_stick_i   (throttle_stick_i),
    .dt_ms_i            (dt_ms_i),
    .thrust_cmd_i       (thrust_cmd_i),
    .yaw_cmd_i          (yaw_cmd_i),
    .roll_cmd_i         (roll_cmd_i),
    .pitch_cmd_i        (pitch_cmd_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .motor_front_right_o(motor_front_right_o),
    .motor_front_left_o (motor_front_left_o),
    .motor_rear_left_o  (motor_rear_left_o),
    .motor_rear_right_o (motor_rear_right_o)
  );

  function automatic qxm_pkg::pwm_t pwm_sat(int v);
    if (v < 0) return '0;
    if (v > PWM_TOP) return qxm_pkg::pwm_t'(PWM_TOP);
    return qxm_pkg::pwm_t'(v);
  endfunction

  function automatic qxm_pkg::motor_set_t mixer_predict(tick_t t);
    qxm_pkg::motor_set_t res;
    qxm_pkg::pwm_t       idle_pwm;
    int                  thr, yaw, rol, pit;
    thr = t.thrust;
    yaw = t.yaw;
    rol = t.roll;
    pit = t.pitch;
    if (t.calib) begin
      for (int k = 0; k < 4; k++) res[k] = pwm_sat(int'(t.stick) + STICK_BIAS);
      return res;
    end
    if (!t.armed) begin
      spun_up = 1'b0;
      return '0;
    end
    idle_pwm = qxm_pkg::pwm_t'(((idle_cfg > IDLE_CAP) ? IDLE_CAP : int'(idle_cfg))
                               * IDLE_GAIN);
    if (!spun_up) begin
      spin_ms = spin_ms + 16'(t.dt);
      if (spin_ms < SPIN_FL_MS) begin
        held = '0;
        held[qxm_pkg::MOTOR_FR] = idle_pwm;
      end else if (spin_ms < SPIN_RL_MS) begin
        held[qxm_pkg::MOTOR_FL] = idle_pwm;
      end else if (spin_ms < SPIN_RR_MS) begin
        held[qxm_pkg::MOTOR_RL] = idle_pwm;
      end else if (spin_ms < SPIN_END_MS) begin
        held[qxm_pkg::MOTOR_RR] = idle_pwm;
      end else if (spin_ms > SPIN_READY_MS) begin
        spun_up = 1'b1;
        spin_ms = '0;
      end
    end
    // mixing may start in the very tick that finishes the spin-up
    if (t.takeoff && spun_up) begin
      held[qxm_pkg::MOTOR_FR] = pwm_sat(thr + yaw - rol + pit);
      held[qxm_pkg::MOTOR_FL] = pwm_sat(thr - yaw + rol + pit);
      held[qxm_pkg::MOTOR_RL] = pwm_sat(thr + yaw + rol - pit);
      held[qxm_pkg::MOTOR_RR] = pwm_sat(thr - yaw - rol - pit);
    end
    return held;
  endfunction

  task automatic send_tick(tick_t t, bit use_typed, qxm_pkg::motor_set_t typed);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    esc_calibration_i = t.calib;
    armed_i           = t.armed;
    taking_off_i      = t.takeoff;
    throttle_stick_i  = t.stick;
    dt_ms_i           = t.dt;
    thrust_cmd_i      = t.thrust;
    yaw_cmd_i         = t.yaw;
    roll_cmd_i        = t.roll;
    pitch_cmd_i       = t.pitch;
    in_valid_i        = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (use_typed) begin
      void'(mixer_predict(t));
      pending_pwm.push_back(typed);
    end else begin
      pending_pwm.push_back(mixer_predict(t));
    end
  endtask

  // only while nothing is in flight
  task automatic write_idle(logic [7:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    idle_cfg = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    int    r;
    r         = $urandom_range(0, 99);
    t.calib   = (r < 5);
    t.armed   = (r >= 10);
    t.takeoff = ($urandom_range(0, 99) < 60);
    t.stick   = 10'($urandom);
    t.dt      = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(100, 255)) : 8'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      // flight-like commands that mostly land inside the pwm range
      t.thrust = 16'($urandom_range(0, 1100));
      t.yaw    = 16'(int'($urandom_range(0, 600)) - 300);
      t.roll   = 16'(int'($urandom_range(0, 600)) - 300);
      t.pitch  = 16'(int'($urandom_range(0, 600)) - 300);
    end else begin
      t.thrust = 16'($urandom);
      t.yaw    = 16'($urandom);
      t.roll   = 16'($urandom);
      t.pitch  = 16'($urandom);
    end
    return t;
  endfunction

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall == 0 && !calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 19);
      if (stall > 0 && !calm) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    qxm_pkg::motor_set_t got, want;
    got[qxm_pkg::MOTOR_FR] = motor_front_right_o;
    got[qxm_pkg::MOTOR_FL] = motor_front_left_o;
    got[qxm_pkg::MOTOR_RL] = motor_rear_left_o;
    got[qxm_pkg::MOTOR_RR] = motor_rear_right_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pwm.size() == 0) begin
        $display("%0t: transaction out with no tick pending", $time);
        mix_errors++;
      end else begin
        want = pending_pwm.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t: motor_%s expected %0d actual %0d", $time, motor_name[k], want[k],
                     got[k]);
            mix_errors++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("quad_x_motor_mixer_sequencer verification failed");
    $finish;
  end

  initial begin
    tick_t               t;
    qxm_pkg::motor_set_t typed;
    logic [7:0]          idle_plan [PHASES];
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    esc_calibration_i = 1'b0;
    armed_i           = 1'b0;
    taking_off_i      = 1'b0;
    throttle_stick_i  = '0;
    dt_ms_i           = '0;
    thrust_cmd_i      = '0;
    yaw_cmd_i         = '0;
    roll_cmd_i        = '0;
    pitch_cmd_i       = '0;
    out_ready_i       = 1'b0;
    idle_cfg          = '0;
    held              = '0;
    spin_ms           = '0;
    spun_up           = 1'b0;
    mix_errors        = 0;
    calm              = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_idle(8'd255);
    foreach (DIRECTED[n]) begin
      t.calib   = DIRECTED[n].calib[0];
      t.armed   = DIRECTED[n].armed[0];
      t.takeoff = DIRECTED[n].takeoff[0];
      t.stick   = 10'(DIRECTED[n].stick);
      t.dt      = 8'(DIRECTED[n].dt);
      t.thrust  = 16'(DIRECTED[n].thrust);
      t.yaw     = 16'(DIRECTED[n].yaw);
      t.roll    = 16'(DIRECTED[n].roll);
      t.pitch   = 16'(DIRECTED[n].pitch);
      typed[qxm_pkg::MOTOR_FR] = qxm_pkg::pwm_t'(DIRECTED[n].fr);
      typed[qxm_pkg::MOTOR_FL] = qxm_pkg::pwm_t'(DIRECTED[n].fl);
      typed[qxm_pkg::MOTOR_RL] = qxm_pkg::pwm_t'(DIRECTED[n].rl);
      typed[qxm_pkg::MOTOR_RR] = qxm_pkg::pwm_t'(DIRECTED[n].rr);
      send_tick(t, DIRECTED[n].fr != UNTYPED, typed);
    end

    idle_plan = '{8'd0, 8'd30, 8'd31, 8'd0, 8'd0};
    idle_plan[3] = 8'($urandom_range(1, 29));
    idle_plan[4] = 8'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      write_idle(idle_plan[p]);
      // no idling on either side in the closing phase
      calm = (p == PHASES - 1);
      repeat (PHASE_TICKS) send_tick(random_tick(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mix_errors == 0) begin
      $display("quad_x_motor_mixer_sequencer verification clean");
    end else begin
      $display("quad_x_motor_mixer_sequencer verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/qxm_pkg.sv
hw/rtl/qxm_mixer.sv
hw/rtl/quad_x_motor_mixer_sequencer.sv
tb/quad_x_motor_mixer_sequencer_test.sv
